@@ sv/ght_pkg.sv @@
// ght_pkg: shared types, codes and helpers of the generational handle table.
// No dependencies.
package ght_pkg;

   localparam int SLOTS_DEF   = 32;
   localparam logic [31:0] GEN_MAX_DEF = 32'hFFFF_FFFF;

   localparam int COUNT_W = 7;
   localparam int NGEN_W  = 33;

   localparam logic [2:0] MODE_INSERT     = 3'd0;
   localparam logic [2:0] MODE_LOOKUP     = 3'd1;
   localparam logic [2:0] MODE_REVOKE_HND = 3'd2;
   localparam logic [2:0] MODE_REVOKE_OBJ = 3'd3;
   localparam logic [2:0] MODE_REVOKE_ALL = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD      = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_OBJ      = 3'd3;
   localparam logic [2:0] ST_NOGEN    = 3'd4;
   localparam logic [2:0] ST_HANDLE   = 3'd5;
   localparam logic [2:0] ST_MISMATCH = 3'd6;

   localparam logic [2:0] KIND_MIN = 3'd1;
   localparam logic [2:0] KIND_MAX = 3'd4;

   typedef struct packed {
      logic              used;
      logic [31:0]       gen;
      logic [2:0]        kind;
      logic [7:0]        rights;
      logic [63:0]       object;
      logic [NGEN_W-1:0] next_gen;
   } slot_type;

   typedef struct packed {
      logic               ok;
      logic [2:0]         status;
      logic               released;
      logic [31:0]        index;
      logic [31:0]        gen;
      logic [63:0]        object;
      logic [2:0]         otype;
      logic [COUNT_W-1:0] count;
      logic               last;
   } res_type;

   function automatic logic kind_valid(input logic [2:0] k);
      return (k >= KIND_MIN) && (k <= KIND_MAX);
   endfunction

   function automatic res_type fail_res(input logic [2:0] st, input logic [COUNT_W-1:0] cnt);
      res_type r;
      r          = '0;
      r.status   = st;
      r.count    = cnt;
      r.last     = 1'b1;
      return r;
   endfunction

endpackage

@@ sv/ght_slot_mem.sv @@
// ght_slot_mem: slot memory, registered read, per-entry valid bits.
// Depends on ght_pkg.
module ght_slot_mem #(
   parameter int SLOTS = ght_pkg::SLOTS_DEF,
   parameter int IDX_W = $clog2(SLOTS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output ght_pkg::slot_type rd_data,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  ght_pkg::slot_type wr_data
);

   ght_pkg::slot_type mem [SLOTS];
   ght_pkg::slot_type q_ff;
   logic [SLOTS-1:0]  valid_ff;
   logic              q_valid_ff;
   ght_pkg::slot_type blank;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         q_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            q_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // unwritten entry reads as the reset state: free, next generation one
   always_comb begin
      blank          = '0;
      blank.next_gen = ght_pkg::NGEN_W'(1);
      rd_data        = q_valid_ff ? q_ff : blank;
   end

endmodule

@@ sv/ght_out_reg.sv @@
// ght_out_reg: one-word output register for the result stream.
// Depends on ght_pkg.
module ght_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  ght_pkg::res_type push_data,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output ght_pkg::res_type rsp_data
);

   logic             full_ff;
   logic             full_in;
   ght_pkg::res_type data_ff;

   assign push_ready = !full_ff || rsp_tready;
   assign rsp_tvalid = full_ff;
   assign rsp_data   = data_ff;

   always_comb begin
      full_in = full_ff;
      if (rsp_tready) begin
         full_in = 1'b0;
      end
      if (push_valid && push_ready) begin
         full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      if (push_valid && push_ready) begin
         data_ff <= push_data;
      end
   end

endmodule

@@ sv/generational_handle_table.sv @@
// generational_handle_table: top level, sequencer over the slot memory.
// Depends on ght_pkg, ght_slot_mem, ght_out_reg.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tuser mode, tdata request fields
//  rsp     | out | rsp_tvalid/rsp_tready  | tuser released, tdata result, tlast
//  csr     | in  | psel/penable, pready=1 | rights_valid_mask at byte 0
//
// One item at a time; req_tready is high only while the sequencer idles.
// Each slot visit is a read state then a check state. Insert probes slots in
// order (up to SLOTS) and then emits; lookup and revoke by handle visit the
// addressed slot and then emit; revoke by object/all makes a count pass, then
// a release pass that emits each release, or a count pass and an emit when
// nothing matches. Early rejects go from accept straight to emit.
// Synchronous reset clears control and the per-slot valid bits at once; no
// clearing pass. A stalled result stream holds the release pass in place.
module generational_handle_table #(
   parameter int          SLOTS   = ght_pkg::SLOTS_DEF,
   parameter logic [31:0] GEN_MAX = ght_pkg::GEN_MAX_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // object_key[63:0], obj_type[66:64], rights[74:67], handle_index[106:75],
   // handle_generation[138:107], object_ok[139], zero pad
   input  logic [143:0] req_tdata,
   // mode[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // ok[0], status[3:1], out_index[35:4], out_generation[67:36],
   // result_key[131:68], out_type[134:132], entry_count[141:135], zero pad
   output logic [143:0] rsp_tdata,
   // released[0]
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CW    = ght_pkg::COUNT_W;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_INS_RD  = 4'd1;
   localparam logic [3:0] S_INS_CHK = 4'd2;
   localparam logic [3:0] S_HND_RD  = 4'd3;
   localparam logic [3:0] S_HND_CHK = 4'd4;
   localparam logic [3:0] S_CNT_RD  = 4'd5;
   localparam logic [3:0] S_CNT_CHK = 4'd6;
   localparam logic [3:0] S_REL_RD  = 4'd7;
   localparam logic [3:0] S_REL_CHK = 4'd8;
   localparam logic [3:0] S_EMIT    = 4'd9;

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);
   localparam logic [CW-1:0]    FULL_CNT  = CW'(SLOTS);

   // csr
   logic [7:0] mask_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {24'd0, mask_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= 8'hFF;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == 1'b0) begin
         mask_ff <= csr_pwdata[7:0];
      end
   end

   // request fields
   logic [63:0] in_key;
   logic [2:0]  in_kind;
   logic [7:0]  in_rights;
   logic [31:0] in_hidx;
   logic [31:0] in_hgen;
   logic        in_objok;

   assign in_key    = req_tdata[63:0];
   assign in_kind   = req_tdata[66:64];
   assign in_rights = req_tdata[74:67];
   assign in_hidx   = req_tdata[106:75];
   assign in_hgen   = req_tdata[138:107];
   assign in_objok  = req_tdata[139];

   // sequencer state
   logic [3:0]       state_ff, state_in;
   logic [2:0]       mode_ff, mode_in;
   logic [63:0]      key_ff, key_in;
   logic [2:0]       kind_ff, kind_in;
   logic [7:0]       rights_ff, rights_in;
   logic [31:0]      hgen_ff, hgen_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    total_ff, total_in;
   logic [CW-1:0]    done_ff, done_in;
   ght_pkg::res_type res_ff, res_in;

   // memory and output
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   ght_pkg::slot_type ent;
   logic              wr_en;
   ght_pkg::slot_type wr_data;
   logic              push_valid, push_ready;
   ght_pkg::res_type  push_data, out_res;

   ght_slot_mem #(.SLOTS(SLOTS), .IDX_W(IDX_W)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ent),
      .wr_en   (wr_en),
      .wr_addr (scan_ff),
      .wr_data (wr_data)
   );

   ght_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (out_res)
   );

   assign rsp_tdata = {2'd0, out_res.count, out_res.otype, out_res.object, out_res.gen,
                       out_res.index, out_res.status, out_res.ok};
   assign rsp_tuser = out_res.released;
   assign rsp_tlast = out_res.last;

   assign req_tready = (state_ff == S_IDLE);

   logic bad_rights_in, ins_free, hnd_ok, scan_match, at_end;
   ght_pkg::slot_type freed;
   ght_pkg::res_type  rel_res;

   assign bad_rights_in = (in_rights & ~mask_ff) != 8'd0;
   assign ins_free      = !ent.used && ent.next_gen != '0
                          && ent.next_gen <= {1'b0, GEN_MAX};
   assign hnd_ok        = ent.used && hgen_ff != 32'd0 && ent.gen == hgen_ff;
   assign scan_match    = ent.used && (mode_ff == ght_pkg::MODE_REVOKE_ALL
                          || (ent.object == key_ff && ent.kind == kind_ff));
   assign at_end        = (scan_ff == LAST_SLOT);

   // freed slot keeps generation and its counter
   always_comb begin
      freed        = ent;
      freed.used   = 1'b0;
      freed.kind   = 3'd0;
      freed.rights = 8'd0;
   end

   always_comb begin
      rel_res          = '0;
      rel_res.ok       = 1'b1;
      rel_res.status   = ght_pkg::ST_OK;
      rel_res.released = 1'b1;
      rel_res.index    = 32'(scan_ff);
      rel_res.gen      = ent.gen;
      rel_res.object   = ent.object;
      rel_res.otype    = ent.kind;
      rel_res.count    = count_ff;
      rel_res.last     = (done_ff + CW'(1)) == total_ff;
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      key_in    = key_ff;
      kind_in   = kind_ff;
      rights_in = rights_ff;
      hgen_in   = hgen_ff;
      scan_in   = scan_ff;
      count_in  = count_ff;
      total_in  = total_ff;
      done_in   = done_ff;
      res_in    = res_ff;
      rd_en     = 1'b0;
      rd_addr   = scan_ff;
      wr_en     = 1'b0;
      wr_data   = freed;
      push_valid = 1'b0;
      push_data  = res_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in   = req_tuser;
               key_in    = in_key;
               kind_in   = in_kind;
               rights_in = in_rights;
               hgen_in   = in_hgen;
               scan_in   = '0;
               total_in  = '0;
               done_in   = '0;
               state_in  = S_EMIT;
               case (req_tuser)
                  ght_pkg::MODE_INSERT: begin
                     if (!ght_pkg::kind_valid(in_kind) || in_rights == 8'd0 || bad_rights_in)
                        res_in = ght_pkg::fail_res(ght_pkg::ST_BAD, count_ff);
                     else if (count_ff >= FULL_CNT)
                        res_in = ght_pkg::fail_res(ght_pkg::ST_FULL, count_ff);
                     else if (!in_objok)
                        res_in = ght_pkg::fail_res(ght_pkg::ST_OBJ, count_ff);
                     else
                        state_in = S_INS_RD;
                  end
                  ght_pkg::MODE_LOOKUP, ght_pkg::MODE_REVOKE_HND: begin
                     if (req_tuser == ght_pkg::MODE_LOOKUP
                         && (!ght_pkg::kind_valid(in_kind) || bad_rights_in)) begin
                        res_in = ght_pkg::fail_res(ght_pkg::ST_BAD, count_ff);
                     end else if (in_hidx >= 32'(SLOTS)) begin
                        res_in = ght_pkg::fail_res(ght_pkg::ST_HANDLE, count_ff);
                     end else begin
                        scan_in  = in_hidx[IDX_W-1:0];
                        state_in = S_HND_RD;
                     end
                  end
                  ght_pkg::MODE_REVOKE_OBJ, ght_pkg::MODE_REVOKE_ALL: begin
                     if (req_tuser == ght_pkg::MODE_REVOKE_OBJ && !ght_pkg::kind_valid(in_kind))
                        res_in = ght_pkg::fail_res(ght_pkg::ST_BAD, count_ff);
                     else
                        state_in = S_CNT_RD;
                  end
                  default: begin
                     res_in = ght_pkg::fail_res(ght_pkg::ST_BAD, count_ff);
                  end
               endcase
            end
         end

         S_INS_RD: begin
            rd_en    = 1'b1;
            state_in = S_INS_CHK;
         end

         S_INS_CHK: begin
            if (ins_free) begin
               wr_en            = 1'b1;
               wr_data.used     = 1'b1;
               wr_data.gen      = ent.next_gen[31:0];
               wr_data.kind     = kind_ff;
               wr_data.rights   = rights_ff;
               wr_data.object   = key_ff;
               wr_data.next_gen = ent.next_gen + ght_pkg::NGEN_W'(1);
               count_in         = count_ff + CW'(1);
               res_in           = '0;
               res_in.ok        = 1'b1;
               res_in.index     = 32'(scan_ff);
               res_in.gen       = ent.next_gen[31:0];
               res_in.object    = key_ff;
               res_in.otype     = kind_ff;
               res_in.count     = count_ff + CW'(1);
               res_in.last      = 1'b1;
               state_in         = S_EMIT;
            end else if (at_end) begin
               res_in   = ght_pkg::fail_res(ght_pkg::ST_NOGEN, count_ff);
               state_in = S_EMIT;
            end else begin
               scan_in  = scan_ff + IDX_W'(1);
               state_in = S_INS_RD;
            end
         end

         S_HND_RD: begin
            rd_en    = 1'b1;
            state_in = S_HND_CHK;
         end

         S_HND_CHK: begin
            state_in = S_EMIT;
            if (!hnd_ok) begin
               res_in = ght_pkg::fail_res(ght_pkg::ST_HANDLE, count_ff);
            end else if (mode_ff == ght_pkg::MODE_LOOKUP) begin
               if (ent.kind != kind_ff || (ent.rights & rights_ff) != rights_ff) begin
                  res_in = ght_pkg::fail_res(ght_pkg::ST_MISMATCH, count_ff);
               end else begin
                  res_in        = ght_pkg::fail_res(ght_pkg::ST_OK, count_ff);
                  res_in.ok     = 1'b1;
                  res_in.object = ent.object;
                  res_in.otype  = ent.kind;
               end
            end else begin
               wr_en        = 1'b1;
               count_in     = count_ff - CW'(1);
               res_in       = rel_res;
               res_in.count = count_ff - CW'(1);
               res_in.last  = 1'b1;
            end
         end

         // first pass counts matches so every result carries the final count
         S_CNT_RD: begin
            rd_en    = 1'b1;
            state_in = S_CNT_CHK;
         end

         S_CNT_CHK: begin
            if (scan_match) begin
               total_in = total_ff + CW'(1);
            end
            if (at_end) begin
               scan_in = '0;
               if (total_in == '0) begin
                  res_in    = ght_pkg::fail_res(ght_pkg::ST_OK, count_ff);
                  res_in.ok = 1'b1;
                  state_in  = S_EMIT;
               end else begin
                  count_in = count_ff - total_in;
                  state_in = S_REL_RD;
               end
            end else begin
               scan_in  = scan_ff + IDX_W'(1);
               state_in = S_CNT_RD;
            end
         end

         S_REL_RD: begin
            rd_en    = 1'b1;
            state_in = S_REL_CHK;
         end

         S_REL_CHK: begin
            if (scan_match) begin
               push_valid = 1'b1;
               push_data  = rel_res;
            end
            if (!scan_match || push_ready) begin
               if (scan_match) begin
                  wr_en   = 1'b1;
                  done_in = done_ff + CW'(1);
               end
               if (at_end) begin
                  state_in = S_IDLE;
               end else begin
                  scan_in  = scan_ff + IDX_W'(1);
                  state_in = S_REL_RD;
               end
            end
         end

         S_EMIT: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      mode_ff   <= mode_in;
      key_ff    <= key_in;
      kind_ff   <= kind_in;
      rights_ff <= rights_in;
      hgen_ff   <= hgen_in;
      scan_ff   <= scan_in;
      total_ff  <= total_in;
      done_ff   <= done_in;
      res_ff    <= res_in;
   end

endmodule
